[hw/rtl/bdq_pkg.sv]
package bdq_pkg;

  // field widths of the stream payloads
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned COUNT_OUT_W = 9;

  // packed bus widths, rounded up to whole bytes
  localparam int unsigned S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((DATA_W + COUNT_OUT_W + 7) / 8) * 8;
  localparam int unsigned S_TUSER_W = FUNC_W;
  localparam int unsigned M_TUSER_W = 2;

  // default number of entries
  localparam int unsigned DEF_CAPACITY = 256;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INS_HEAD = 3'd0,
    FUNC_INS_TAIL = 3'd1,
    FUNC_RM_HEAD  = 3'd2,
    FUNC_RM_TAIL  = 3'd3,
    FUNC_RD_HEAD  = 3'd4,
    FUNC_RD_TAIL  = 3'd5,
    FUNC_RD_INDEX = 3'd6,
    FUNC_SIZE     = 3'd7
  } func_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic exec;     // apply the operation to pointers and store
    logic load;     // move the result into the output register
  } cmd_t;

endpackage

[hw/rtl/bounded_deque_with_indexed_read.sv]
// channel   dir  tdata (low bit up)                    tuser (low bit up)
// s_axis    in   entry_data[31:0], position[39:32]     func[2:0]
// m_axis    out  read_data[31:0], count_now[40:32]     read_valid[0], refused[1]
//
// each transaction passes three steps: capture, store access, result load; the
// single port store with its registered read sets this sequence
// reset clears head pointer, count and output valid; the store is not cleared
// a new transaction is taken while the previous result waits on m_axis; the
// sequencer holds in the load step until the output register frees up
module bounded_deque_with_indexed_read #(
  parameter int unsigned CAPACITY = bdq_pkg::DEF_CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bdq_pkg::S_TDATA_W-1:0] s_axis_tdata,  // entry_data, position
  input  logic [bdq_pkg::S_TUSER_W-1:0] s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bdq_pkg::M_TDATA_W-1:0] m_axis_tdata,  // read_data, count_now, zero pad
  output logic [bdq_pkg::M_TUSER_W-1:0] m_axis_tuser   // read_valid, refused
);
  import bdq_pkg::*;

  cmd_t                   cmd;
  logic [DATA_W-1:0]      read_data;
  logic                   read_valid;
  logic                   refused;
  logic [COUNT_OUT_W-1:0] count_now;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bdq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (s_axis_tuser[FUNC_W-1:0]),
    .entry_data_i (s_axis_tdata[DATA_W-1:0]),
    .position_i   (s_axis_tdata[DATA_W+POS_W-1:DATA_W]),
    .read_data_o  (read_data),
    .read_valid_o (read_valid),
    .refused_o    (refused),
    .count_now_o  (count_now)
  );

  // output packing
  assign m_axis_tdata = M_TDATA_W'({count_now, read_data});
  assign m_axis_tuser = {refused, read_valid};

  // a failed read never carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !read_valid |-> read_data == '0)
    else $error("read data nonzero without read_valid");

  // a refusal and a successful read never come together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(read_valid && refused))
    else $error("read_valid and refused both set");

  // the count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(count_now) <= 32'(CAPACITY))
    else $error("count beyond capacity");

  // only one transaction in the datapath at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

endmodule

[hw/rtl/bdq_ram.sv]
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bdq_ctrl.sv]
module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdq_pkg::cmd_t cmd_o
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // result may enter the output register once it is empty or being drained
  assign load       = (state_q == S_LOAD) && (!out_valid_q || out_ready_i);

  assign cmd_o.capture = accept;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.load    = load;
  assign out_valid_o   = out_valid_q;

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/bdq_dpath.sv]
module bdq_dpath #(
  parameter int unsigned CAPACITY = bdq_pkg::DEF_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bdq_pkg::cmd_t                   cmd_i,
  input  logic [bdq_pkg::FUNC_W-1:0]      func_i,
  input  logic [bdq_pkg::DATA_W-1:0]      entry_data_i,
  input  logic [bdq_pkg::POS_W-1:0]       position_i,
  output logic [bdq_pkg::DATA_W-1:0]      read_data_o,
  output logic                            read_valid_o,
  output logic                            refused_o,
  output logic [bdq_pkg::COUNT_OUT_W-1:0] count_now_o
);
  import bdq_pkg::*;

  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned OW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned SW = OW + 1;

  // latched transaction
  func_e             func_q;
  logic [DATA_W-1:0] data_q;
  logic [POS_W-1:0]  pos_q;

  // queue state
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rd_valid_q, rd_valid_d;
  logic          refused_q, refused_d;

  // output register
  logic [DATA_W-1:0]      out_data_q;
  logic                   out_valid_q;
  logic                   out_refused_q;
  logic [COUNT_OUT_W-1:0] out_count_q;

  // store access
  logic              full, empty;
  logic [OW-1:0]     offset;
  logic [SW-1:0]     sum, slot;
  logic [PW-1:0]     addr;
  logic              we, re;
  logic [DATA_W-1:0] rdata;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  // element offset from the head for the current operation
  always_comb begin
    case (func_q)
      FUNC_INS_TAIL: offset = OW'(count_q);
      FUNC_RM_HEAD:  offset = OW'(1);
      FUNC_RD_TAIL:  offset = OW'(count_q) - OW'(1);
      FUNC_RD_INDEX: offset = OW'(pos_q);
      default:       offset = '0;
    endcase
  end

  // slot of an element counted from the head, wrapped once
  assign sum  = SW'(head_q) + SW'(offset);
  assign slot = (sum >= SW'(CAPACITY)) ? (sum - SW'(CAPACITY)) : sum;

  // operation decode
  always_comb begin
    addr       = PW'(slot);
    head_d     = head_q;
    count_d    = count_q;
    we         = 1'b0;
    re         = 1'b0;
    rd_valid_d = 1'b0;
    refused_d  = 1'b0;
    case (func_q)
      FUNC_INS_HEAD: begin
        addr = (head_q == '0) ? PW'(CAPACITY - 1) : (head_q - PW'(1));
        if (full) begin
          refused_d = 1'b1;
        end else begin
          we      = 1'b1;
          head_d  = addr;
          count_d = count_q + CW'(1);
        end
      end
      FUNC_INS_TAIL: begin
        if (full) begin
          refused_d = 1'b1;
        end else begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      FUNC_RM_HEAD: begin
        if (empty) begin
          refused_d = 1'b1;
        end else begin
          head_d  = PW'(slot);
          count_d = count_q - CW'(1);
        end
      end
      FUNC_RM_TAIL: begin
        if (empty) begin
          refused_d = 1'b1;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      FUNC_RD_HEAD: begin
        rd_valid_d = !empty;
        re         = !empty;
      end
      FUNC_RD_TAIL: begin
        rd_valid_d = !empty;
        re         = !empty;
      end
      FUNC_RD_INDEX: begin
        rd_valid_d = (OW'(pos_q) < OW'(count_q));
        re         = rd_valid_d;
      end
      FUNC_SIZE: begin
      end
      default: begin
      end
    endcase
  end

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && we),
    .re_i    (cmd_i.exec && re),
    .addr_i  (addr),
    .wdata_i (data_q),
    .rdata_o (rdata)
  );

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      data_q <= entry_data_i;
      pos_q  <= position_i;
    end
  end

  // pointer and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      rd_valid_q <= 1'b0;
      refused_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q     <= head_d;
      count_q    <= count_d;
      rd_valid_q <= rd_valid_d;
      refused_q  <= refused_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q    <= rd_valid_q ? rdata : '0;
      out_valid_q   <= rd_valid_q;
      out_refused_q <= refused_q;
      out_count_q   <= COUNT_OUT_W'(count_q);
    end
  end

  assign read_data_o  = out_data_q;
  assign read_valid_o = out_valid_q;
  assign refused_o    = out_refused_q;
  assign count_now_o  = out_count_q;

endmodule

[sim/tb_bounded_deque_with_indexed_read.sv]
`timescale 1ns / 1ps

module tb_bounded_deque_with_indexed_read;
  import bdq_pkg::*;

  localparam int DEPTH      = DEF_CAPACITY;
  localparam int STALL_MAX  = 1000;
  localparam int SETTLE_CYC = 8;

  // expected result of one transaction
  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic                   read_valid;
    logic                   refused;
    logic [COUNT_OUT_W-1:0] count_now;
  } deque_result_t;

  // one row of the directed sequence
  typedef struct packed {
    func_e             op;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              fixed;
    deque_result_t     want;
  } dir_row_t;

  localparam deque_result_t PREDICT = '0;

  // empty list first, then a short fill with extreme records, reads and a full drain
  localparam dir_row_t DIR_ROWS [24] = '{
    '{FUNC_RD_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd0}},
    '{FUNC_RD_TAIL,  32'hffff_ffff, 8'hff, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd0}},
    '{FUNC_RD_INDEX, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd0}},
    '{FUNC_RM_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b1, 9'd0}},
    '{FUNC_RM_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b1, 9'd0}},
    '{FUNC_SIZE,     32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd0}},
    '{FUNC_INS_HEAD, 32'hffff_ffff, 8'hff, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd1}},
    '{FUNC_INS_TAIL, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd2}},
    '{FUNC_INS_HEAD, 32'ha5a5_a5a5, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd3}},
    '{FUNC_INS_TAIL, 32'h5a5a_5a5a, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd4}},
    '{FUNC_RD_HEAD,  32'h0000_0000, 8'h00, 1'b0, PREDICT},
    '{FUNC_RD_TAIL,  32'h0000_0000, 8'h00, 1'b0, PREDICT},
    '{FUNC_RD_INDEX, 32'h0000_0000, 8'h01, 1'b0, PREDICT},
    '{FUNC_RD_INDEX, 32'h0000_0000, 8'h03, 1'b0, PREDICT},
    '{FUNC_RD_INDEX, 32'h0000_0000, 8'h04, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd4}},
    '{FUNC_RD_INDEX, 32'hffff_ffff, 8'hff, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd4}},
    '{FUNC_SIZE,     32'hffff_ffff, 8'hff, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd4}},
    '{FUNC_RM_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd3}},
    '{FUNC_RD_HEAD,  32'h0000_0000, 8'h00, 1'b0, PREDICT},
    '{FUNC_RM_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd2}},
    '{FUNC_RD_TAIL,  32'h0000_0000, 8'h00, 1'b0, PREDICT},
    '{FUNC_RM_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd1}},
    '{FUNC_RM_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b0, 9'd0}},
    '{FUNC_RM_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 1'b1, 9'd0}}
  };

  localparam func_e QUERY_OPS [4] = '{FUNC_RD_HEAD, FUNC_RD_TAIL, FUNC_RD_INDEX, FUNC_SIZE};

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 s_axis_tvalid  = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata   = '0;  // entry_data, position
  logic [S_TUSER_W-1:0] s_axis_tuser   = '0;  // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // read_data, count_now, zero pad
  logic [M_TUSER_W-1:0] m_axis_tuser;         // read_valid, refused

  // shadow copy of the list contents
  logic [DATA_W-1:0] shadow_entries [DEPTH];
  int                shadow_head  = 0;
  int                shadow_count = 0;

  deque_result_t pending_results [$];
  int            mismatch_count = 0;
  int            ops_sent       = 0;
  int            quiet_cycles   = 0;
  bit            send_lazy      = 1'b1;
  bit            recv_lazy      = 1'b1;

  bounded_deque_with_indexed_read i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // apply one operation to the shadow list and return its result
  function automatic deque_result_t deque_apply(func_e op, logic [DATA_W-1:0] data,
                                                logic [POS_W-1:0] pos);
    deque_result_t res;
    res = '0;
    case (op)
      FUNC_INS_HEAD: begin
        if (shadow_count >= DEPTH) begin
          res.refused = 1'b1;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_entries[shadow_head] = data;
          shadow_count++;
        end
      end
      FUNC_INS_TAIL: begin
        if (shadow_count >= DEPTH) begin
          res.refused = 1'b1;
        end else begin
          shadow_entries[(shadow_head + shadow_count) % DEPTH] = data;
          shadow_count++;
        end
      end
      FUNC_RM_HEAD: begin
        if (shadow_count == 0) begin
          res.refused = 1'b1;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      FUNC_RM_TAIL: begin
        if (shadow_count == 0) res.refused = 1'b1;
        else shadow_count--;
      end
      FUNC_RD_HEAD: begin
        if (shadow_count > 0) begin
          res.read_data  = shadow_entries[shadow_head];
          res.read_valid = 1'b1;
        end
      end
      FUNC_RD_TAIL: begin
        if (shadow_count > 0) begin
          res.read_data  = shadow_entries[(shadow_head + shadow_count - 1) % DEPTH];
          res.read_valid = 1'b1;
        end
      end
      FUNC_RD_INDEX: begin
        if (int'(pos) < shadow_count) begin
          res.read_data  = shadow_entries[(shadow_head + int'(pos)) % DEPTH];
          res.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    res.count_now = shadow_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("%0t ns %s: got %h want %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // drive one transaction after a random gap (none unless send_lazy) and record its expected result
  task automatic send_op(func_e op, logic [DATA_W-1:0] data, logic [POS_W-1:0] pos,
                         bit fixed, deque_result_t fixed_want);
    int            gap;
    deque_result_t want;
    gap = send_lazy ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, data};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    want = deque_apply(op, data, pos);
    if (fixed) want = fixed_want;
    pending_results.push_back(want);
    ops_sent++;
    // switch idling on both sides now and then
    if (ops_sent % 50 == 0) begin
      send_lazy = ($urandom_range(0, 3) != 0);
      recv_lazy = ($urandom_range(0, 3) != 0);
    end
  endtask

  // random operation with given insert and remove weights in percent
  task automatic random_op(int ins_pct, int rm_pct);
    int                draw;
    func_e             op;
    logic [POS_W-1:0]  pos;
    draw = $urandom_range(0, 99);
    pos  = POS_W'($urandom_range(0, 255));
    if (draw < ins_pct) begin
      op = $urandom_range(0, 1) ? FUNC_INS_TAIL : FUNC_INS_HEAD;
    end else if (draw < ins_pct + rm_pct) begin
      op = $urandom_range(0, 1) ? FUNC_RM_TAIL : FUNC_RM_HEAD;
    end else begin
      op = QUERY_OPS[$urandom_range(0, 3)];
      // mostly in-range indexes, some anywhere
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        pos = POS_W'($urandom_range(0, shadow_count - 1));
    end
    send_op(op, $urandom, pos, 1'b0, PREDICT);
  endtask

  // hold off the sender until every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed sequence
    foreach (DIR_ROWS[i])
      send_op(DIR_ROWS[i].op, DIR_ROWS[i].data, DIR_ROWS[i].pos,
              DIR_ROWS[i].fixed, DIR_ROWS[i].want);
    wait_drained();

    // fill to capacity, then push against the full list
    while (shadow_count < DEPTH) random_op(92, 0);
    repeat (12) random_op(70, 0);
    wait_drained();

    // mix that drifts down from full
    repeat (90) random_op(25, 45);

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("bounded_deque_with_indexed_read: match");
    end else begin
      $display("bounded_deque_with_indexed_read: mismatch");
    end
    $finish;
  end

  // result side: random stalls (none unless recv_lazy), then compare against the oldest expectation
  initial begin : result_sink
    int            stall;
    deque_result_t want;
    @(posedge rst_ni);
    forever begin
      stall = recv_lazy ? $urandom_range(0, 15) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[DATA_W-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.read_data)
          report_mismatch("read_data", m_axis_tdata[DATA_W-1:0], want.read_data);
        if (m_axis_tuser[0] !== want.read_valid)
          report_mismatch("read_valid", DATA_W'(m_axis_tuser[0]), DATA_W'(want.read_valid));
        if (m_axis_tuser[1] !== want.refused)
          report_mismatch("refused", DATA_W'(m_axis_tuser[1]), DATA_W'(want.refused));
        if (m_axis_tdata[DATA_W+COUNT_OUT_W-1:DATA_W] !== want.count_now)
          report_mismatch("count_now", DATA_W'(m_axis_tdata[DATA_W+COUNT_OUT_W-1:DATA_W]),
                          DATA_W'(want.count_now));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("bounded_deque_with_indexed_read: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
